>>> src/sldu_pkg.sv
// Shared types, constants and keystream arithmetic for the substitution
// stream decrypt unit. No dependencies.
package sldu_pkg;

  localparam int unsigned NUM_LANES = 4;

  localparam logic [15:0] LOW_MULT  = 16'h7f8d;
  localparam logic [15:0] HIGH_MULT = 16'h2345;
  localparam logic [15:0] LOW_MOD   = 16'hfff1;
  localparam logic [15:0] HIGH_MOD  = 16'hffd9;
  // 2^16 reduced by each modulus
  localparam logic [19:0] LOW_FOLD  = 20'd15;
  localparam logic [19:0] HIGH_FOLD = 20'd39;

  typedef enum logic [1:0] {
    OP_TABLE_WR = 2'd0,
    OP_SEED     = 2'd1,
    OP_DECRYPT  = 2'd2
  } op_e;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } tbl_wr_t;

  typedef logic [NUM_LANES-1:0][7:0] lane_bytes_t;

  // (x * mult) mod modulus, with the product folded twice at 2^16 and one
  // final compare and subtract. Bounds hold for both generators.
  function automatic logic [15:0] mcg_step(input logic [15:0] x,
                                           input logic [15:0] mult,
                                           input logic [15:0] modulus,
                                           input logic [19:0] fold);
    logic [31:0] prod;
    logic [19:0] s1;
    logic [16:0] s2;
    logic [15:0] res;
    prod = {16'd0, x} * {16'd0, mult};
    s1   = ({4'd0, prod[31:16]} * fold) + {4'd0, prod[15:0]};
    s2   = ({13'd0, s1[19:16]} * fold[16:0]) + {1'b0, s1[15:0]};
    if (s2 >= {1'b0, modulus}) begin
      res = 16'(s2 - {1'b0, modulus});
    end else begin
      res = s2[15:0];
    end
    return res;
  endfunction

endpackage

>>> src/sldu_lane.sv
// One byte lane: a private copy of the 256-entry substitution table with a
// registered read port. Depends on sldu_pkg.
module sldu_lane import sldu_pkg::*; (
  input  logic       clk_i,
  input  tbl_wr_t    wr_i,
  input  logic       rd_en_i,
  input  logic [7:0] rd_addr_i,
  output logic [7:0] rd_data_o
);

  logic [7:0] mem_q [256];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // hold read data until the next item enters
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/sldu_keygen.sv
// Keystream generator: the two key halves and the registered keystream word
// of the item in flight. Depends on sldu_pkg.
module sldu_keygen import sldu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_load_i,
  input  logic [31:0] seed_i,
  input  logic        step_i,
  output logic [31:0] ks_o
);

  logic [15:0] low_q, low_d, high_q, high_d;
  logic [15:0] low_next, high_next;
  logic [31:0] ks_q;

  assign low_next  = mcg_step(low_q, LOW_MULT, LOW_MOD, LOW_FOLD);
  assign high_next = mcg_step(high_q, HIGH_MULT, HIGH_MOD, HIGH_FOLD);

  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    if (seed_load_i) begin
      low_d  = (seed_i[15:0] == 16'd0) ? LOW_MULT : seed_i[15:0];
      high_d = (seed_i[31:16] == 16'd0) ? HIGH_MULT : seed_i[31:16];
    end else if (step_i) begin
      low_d  = low_next;
      high_d = high_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_MULT;
      high_q <= HIGH_MULT;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      ks_q <= {high_next, low_next};
    end
  end

  assign ks_o = ks_q;

endmodule

>>> src/sldu_merge.sv
// Merge stage: joins the lane bytes, applies the keystream and holds the
// result in the output register. Owns pipeline flow control. Depends on sldu_pkg.
module sldu_merge import sldu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic        last_i,
  input  lane_bytes_t lane_data_i,
  input  logic [31:0] ks_i,
  output logic        can_load_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [31:0] plain_word_o,
  output logic        result_is_last_o
);

  logic        s1_valid_q, s1_valid_d;
  logic        s1_last_q;
  logic        s2_valid_q, s2_valid_d;
  logic [31:0] s2_word_q;
  logic        s2_last_q;
  logic        s2_load;

  assign s2_load    = !s2_valid_q || out_ready_i;
  assign can_load_o = !s1_valid_q || s2_load;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s2_valid_d = s2_valid_q;
    if (s2_load) begin
      s2_valid_d = s1_valid_q;
      s1_valid_d = 1'b0;
    end
    if (load_i) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_last_q <= last_i;
    end
    if (s2_load && s1_valid_q) begin
      s2_word_q <= lane_data_i ^ ks_i;
      s2_last_q <= s1_last_q;
    end
  end

  assign out_valid_o      = s2_valid_q;
  assign plain_word_o     = s2_word_q;
  assign result_is_last_o = s2_last_q;

endmodule

>>> src/substitution_lcg_stream_decrypt_unit.sv
// Substitution and congruential keystream stream decryptor, top level.
// Uses sldu_pkg, sldu_lane, sldu_keygen and sldu_merge.
//
// Input channel (in_valid_i / in_ready_o) carries one item per handshake:
//   opcode 0 writes one substitution table entry, opcode 1 loads the key
//   seed, opcode 2 decrypts one 32-bit word, opcode 3 is dropped. Only
//   decrypt items produce a result on the output channel
//   (out_valid_o / out_ready_i).
// Four byte lanes, each with its own copy of the table, substitute the
// bytes of a word in parallel; the merge stage joins them and XORs the
// keystream word advanced by the key generator.
// A decrypt item is registered in each lane's table read port and in the
// keystream register, then in the output register. Throughput: one item
// per cycle unless the receiver stalls, set by the key update (constant
// multiply and folded modulo per half) and each lane's one-read port.
// Reset clears the pipeline and loads the key halves 0x7f8d and 0x2345;
// table contents are undefined until written. When the receiver stalls,
// the output register and one item in the table read stage are held and
// in_ready_o drops once both are full; in_ready_o is high whenever the
// output register is empty or being taken.
module substitution_lcg_stream_decrypt_unit import sldu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  table_index_i,
  input  logic [7:0]  table_value_i,
  input  logic [31:0] key_seed_i,
  input  logic [31:0] data_word_i,
  input  logic        word_is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] plain_word_o,
  output logic        result_is_last_o
);

  logic        accept;
  logic        do_decrypt;
  logic        do_seed;
  tbl_wr_t     tbl_wr;
  lane_bytes_t lane_data;
  logic [31:0] ks;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    do_decrypt = 1'b0;
    do_seed    = 1'b0;
    tbl_wr     = '{en: 1'b0, addr: table_index_i, data: table_value_i};
    unique case (opcode_i)
      OP_TABLE_WR: tbl_wr.en = accept;
      OP_SEED:     do_seed = accept;
      OP_DECRYPT:  do_decrypt = accept;
      default: ;
    endcase
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    sldu_lane u_lane (
      .clk_i     (clk_i),
      .wr_i      (tbl_wr),
      .rd_en_i   (do_decrypt),
      .rd_addr_i (data_word_i[8*g +: 8]),
      .rd_data_o (lane_data[g])
    );
  end

  sldu_keygen u_keygen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_load_i (do_seed),
    .seed_i      (key_seed_i),
    .step_i      (do_decrypt),
    .ks_o        (ks)
  );

  sldu_merge u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (do_decrypt),
    .last_i           (word_is_last_i),
    .lane_data_i      (lane_data),
    .ks_i             (ks),
    .can_load_o       (in_ready_o),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .plain_word_o     (plain_word_o),
    .result_is_last_o (result_is_last_o)
  );

endmodule

>>> src/sldu_checker.sv
// Port-level checks for the stream decrypt unit, bound to the top level.
// Depends on sldu_pkg and substitution_lcg_stream_decrypt_unit.
module sldu_checker import sldu_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  opcode_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] plain_word_o,
  input logic        result_is_last_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(plain_word_o)
      && $stable(result_is_last_o))
    else $error("stalled result changed or dropped");

  // a fresh result traces back to an accepted decrypt item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && opcode_i == OP_DECRYPT, 2))
    else $error("result without a decrypt item");

  // no input stall while the output register drains or is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled while output is free");

endmodule

bind substitution_lcg_stream_decrypt_unit sldu_checker u_sldu_checker (.*);
